// ===== sv/rprb_pkg.sv =====
// ----------------------------------------------------------------------------
// rprb_pkg
// shared types, constants and helpers of the rtp packet reorder buffer
// ----------------------------------------------------------------------------
package rprb_pkg;

    localparam int LEN_W    = 11;
    localparam int SEQ_W    = 16;
    localparam int FRAG_W   = 16;
    localparam int HANDLE_W = 16;

    localparam logic [LEN_W-1:0] HDR_BYTES = 11'd12;
    localparam int TS_PACKET = 188;
    // reciprocal of the transport packet size, exact for every 11-bit length
    localparam int RECIP_SHIFT = 19;
    localparam int RECIP_MUL   = ((1 << RECIP_SHIFT) + TS_PACKET - 1) / TS_PACKET;

    typedef struct packed {
        logic [LEN_W-1:0]    pkt_len;
        logic [SEQ_W-1:0]    seq_num;
        logic [FRAG_W-1:0]   frag_index;
        logic [HANDLE_W-1:0] payload_handle;
        logic                pass;
    } item_t;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic                skip;
        logic [LEN_W-1:0]    len;
    } result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } back_state_t;

    // true when the length is a whole number of transport packets
    function automatic logic is_ts_multiple(input logic [LEN_W-1:0] len);
        logic [LEN_W+12-1:0] prod;
        logic [3:0]          quot;
        logic [LEN_W+4-1:0]  back;
        begin
            prod = (LEN_W+12)'(len) * (LEN_W+12)'(RECIP_MUL);
            quot = 4'(prod >> RECIP_SHIFT);
            back = (LEN_W+4)'(quot) * (LEN_W+4)'(TS_PACKET);
            return back == (LEN_W+4)'(len);
        end
    endfunction

    function automatic logic [LEN_W-1:0] strip_len(input logic [LEN_W-1:0] len);
        return (len > HDR_BYTES) ? len - HDR_BYTES : '0;
    endfunction

endpackage

// ===== sv/rprb_if.sv =====
// ----------------------------------------------------------------------------
// rprb interfaces
// valid/ready channels for packet descriptors in and reorder results out
// ----------------------------------------------------------------------------
interface rprb_in_if;
    logic        valid;
    logic        ready;
    logic [10:0] pkt_len;
    logic [15:0] seq_num;
    logic [15:0] frag_index;
    logic [15:0] payload_handle;

    modport source (output valid, pkt_len, seq_num, frag_index, payload_handle,
                    input ready);
    modport sink   (input valid, pkt_len, seq_num, frag_index, payload_handle,
                    output ready);
endinterface

interface rprb_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] out_handle;
    logic        skip_header;
    logic [10:0] out_len;
    logic        last;

    modport source (output valid, out_handle, skip_header, out_len, last,
                    input ready);
    modport sink   (input valid, out_handle, skip_header, out_len, last,
                    output ready);
endinterface

// ===== sv/rprb_front.sv =====
// ----------------------------------------------------------------------------
// rprb_front
// accepts descriptor words and tags pass-through packets
// ----------------------------------------------------------------------------
module rprb_front (
    rprb_in_if.sink         in,
    input  logic            q_full,
    output logic            q_push,
    output rprb_pkg::item_t q_item
);
    import rprb_pkg::*;

    assign in.ready = !q_full;
    assign q_push   = in.valid && !q_full;

    always_comb
    begin
        q_item.pkt_len        = in.pkt_len;
        q_item.seq_num        = in.seq_num;
        q_item.frag_index     = in.frag_index;
        q_item.payload_handle = in.payload_handle;
        q_item.pass           = is_ts_multiple(in.pkt_len);
    end
endmodule

// ===== sv/rprb_queue.sv =====
// ----------------------------------------------------------------------------
// rprb_queue
// two-entry queue of classified descriptors between front and back
// ----------------------------------------------------------------------------
module rprb_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  rprb_pkg::item_t push_item,
    output logic            full,
    input  logic            pop,
    output logic            not_empty,
    output rprb_pkg::item_t head
);
    import rprb_pkg::*;

    item_t      mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full      = count_reg == 2'd2;
    assign not_empty = count_reg != 2'd0;
    assign head      = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end
endmodule

// ===== sv/rprb_back.sv =====
// ----------------------------------------------------------------------------
// rprb_back
// slot table, wanted-pair tracking, drain scan and output register
// ----------------------------------------------------------------------------
module rprb_back #(
    parameter int SLOTS    = 15,
    parameter int SEQ_WRAP = 256
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    input  rprb_pkg::item_t q_head,
    output logic            q_pop,
    rprb_out_if.source      out
);
    import rprb_pkg::*;

    localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int HELD_W = $clog2(SLOTS + 1);
    localparam logic [16:0] FRAG_SAT = 17'h10000;

    back_state_t state_reg, state_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              sent_reg, sent_next;

    logic [SLOTS-1:0]  vld_reg, vld_next;
    logic [SEQ_W-1:0]  sseq_reg   [SLOTS];
    logic [FRAG_W-1:0] sfrag_reg  [SLOTS];
    logic [LEN_W-1:0]  slen_reg   [SLOTS];
    logic [HANDLE_W-1:0] shdl_reg [SLOTS];

    logic [HELD_W-1:0] held_reg, held_next;
    logic [SEQ_W-1:0]  ws_reg, ws_next;
    logic              wsk_reg, wsk_next;
    logic [16:0]       wf_reg, wf_next;
    logic              wfk_reg, wfk_next;
    logic [FRAG_W-1:0] tf_reg, tf_next;
    logic              tv_reg, tv_next;
    logic [FRAG_W-1:0] prior_reg, prior_next;
    logic              pm_reg, pm_next;
    logic              pd_reg, pd_next;
    logic              cp_reg, cp_next;

    result_t pend_reg, pend_next;
    logic    pend_v_reg, pend_v_next;
    result_t out_reg, out_next;
    logic    out_last_reg, out_last_next;
    logic    out_v_reg, out_v_next;

    logic             ins_en;
    logic [IDX_W-1:0] ins_idx;
    logic [IDX_W-1:0] free_idx;
    logic             out_free;
    logic             match;

    assign out_free        = !out_v_reg || out.ready;
    assign out.valid       = out_v_reg;
    assign out.out_handle  = out_reg.handle;
    assign out.skip_header = out_reg.skip;
    assign out.out_len     = out_reg.len;
    assign out.last        = out_last_reg;

    assign match = vld_reg[idx_reg] && sseq_reg[idx_reg] == ws_reg
                   && {1'b0, sfrag_reg[idx_reg]} == wf_reg;

    // first free slot
    always_comb
    begin
        free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!vld_reg[i])
            begin
                free_idx = IDX_W'(i);
            end
        end
    end

    function automatic logic [SEQ_W-1:0] seq_inc(input logic [SEQ_W-1:0] s);
        logic [SEQ_W:0] t;
        begin
            t = {1'b0, s} + 1'b1;
            if (t == (SEQ_W+1)'(SEQ_WRAP) || t[SEQ_W])
            begin
                t = '0;
            end
            return t[SEQ_W-1:0];
        end
    endfunction

    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        sent_next     = sent_reg;
        vld_next      = vld_reg;
        held_next     = held_reg;
        ws_next       = ws_reg;
        wsk_next      = wsk_reg;
        wf_next       = wf_reg;
        wfk_next      = wfk_reg;
        tf_next       = tf_reg;
        tv_next       = tv_reg;
        prior_next    = prior_reg;
        pm_next       = pm_reg;
        pd_next       = pd_reg;
        cp_next       = cp_reg;
        pend_next     = pend_reg;
        pend_v_next   = pend_v_reg;
        out_next      = out_reg;
        out_last_next = out_last_reg;
        out_v_next    = out_v_reg && !out.ready;
        q_pop         = 1'b0;
        ins_en        = 1'b0;
        ins_idx       = free_idx;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop     = 1'b1;
                    idx_next  = '0;
                    sent_next = 1'b0;
                    state_next = ST_SCAN;
                    if (q_head.pass)
                    begin
                        pend_next   = '{q_head.payload_handle, 1'b0, q_head.pkt_len};
                        pend_v_next = 1'b1;
                    end
                    else
                    begin
                        if (cp_next)
                        begin
                            vld_next  = '0;
                            held_next = '0;
                            ws_next   = q_head.seq_num;
                            wsk_next  = 1'b1;
                            wf_next   = {1'b0, q_head.frag_index};
                            wfk_next  = 1'b1;
                            cp_next   = 1'b0;
                        end
                        if (!wsk_next)
                        begin
                            ws_next  = q_head.seq_num;
                            wsk_next = 1'b1;
                        end
                        if (!wfk_next)
                        begin
                            wf_next  = {1'b0, q_head.frag_index};
                            wfk_next = 1'b1;
                        end
                        if (q_head.frag_index == '0)
                        begin
                            if (held_next == '0)
                            begin
                                pm_next = 1'b1;
                            end
                            else
                            begin
                                tf_next = prior_reg;
                                tv_next = 1'b1;
                            end
                        end
                        if (q_head.seq_num != ws_next && held_next == '0 && !pm_next)
                        begin
                            ws_next = q_head.seq_num;
                        end
                        prior_next = q_head.frag_index;

                        if (!pm_next && q_head.seq_num == ws_next
                            && {1'b0, q_head.frag_index} == wf_next)
                        begin
                            // expected packet goes straight out
                            pend_next   = '{q_head.payload_handle, 1'b1,
                                            strip_len(q_head.pkt_len)};
                            pend_v_next = 1'b1;
                            if (wf_next < FRAG_SAT)
                            begin
                                wf_next = wf_next + 17'd1;
                            end
                        end
                        else
                        begin
                            // a clear in this word frees slot zero first
                            if (held_next != HELD_W'(SLOTS))
                            begin
                                ins_en    = 1'b1;
                                ins_idx   = (held_next == '0) ? '0 : free_idx;
                                vld_next[ins_idx] = 1'b1;
                                held_next = held_next + 1'b1;
                            end
                            if (held_next >= HELD_W'(SLOTS))
                            begin
                                if (pm_next)
                                begin
                                    pm_next = 1'b0;
                                    pd_next = 1'b1;
                                end
                                else
                                begin
                                    if (tv_next && wf_next == {1'b0, tf_next})
                                    begin
                                        ws_next = seq_inc(ws_next);
                                        wf_next = '0;
                                        tv_next = 1'b0;
                                    end
                                    else if (wf_next < FRAG_SAT)
                                    begin
                                        wf_next = wf_next + 17'd1;
                                    end
                                    cp_next = 1'b1;
                                end
                            end
                        end
                    end
                end
            end

            ST_SCAN:
            begin
                if (held_reg == '0 || pm_reg)
                begin
                    state_next = ST_FINISH;
                end
                else if (!(match && pend_v_reg && !out_free))
                begin
                    if (match)
                    begin
                        if (pend_v_reg)
                        begin
                            out_next      = pend_reg;
                            out_last_next = 1'b0;
                            out_v_next    = 1'b1;
                        end
                        pend_next   = '{shdl_reg[idx_reg], 1'b1, strip_len(slen_reg[idx_reg])};
                        pend_v_next = 1'b1;
                        vld_next[idx_reg] = 1'b0;
                        held_next   = held_reg - 1'b1;
                        sent_next   = 1'b1;
                        if (tv_reg && wf_reg == {1'b0, tf_reg})
                        begin
                            ws_next = seq_inc(ws_reg);
                            wf_next = '0;
                            tv_next = 1'b0;
                        end
                        else if (wf_reg < FRAG_SAT)
                        begin
                            wf_next = wf_reg + 17'd1;
                        end
                    end
                    if (held_next == '0)
                    begin
                        state_next = ST_FINISH;
                    end
                    else if (idx_reg == IDX_W'(SLOTS - 1))
                    begin
                        idx_next = '0;
                        if (sent_next)
                        begin
                            sent_next = 1'b0;
                        end
                        else if (pd_reg)
                        begin
                            // no match after prefill: skip one sequence
                            ws_next = seq_inc(ws_reg);
                            wf_next = '0;
                            pd_next = 1'b0;
                        end
                        else
                        begin
                            state_next = ST_FINISH;
                        end
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end

            ST_FINISH:
            begin
                if (!pend_v_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    out_next      = pend_reg;
                    out_last_next = 1'b1;
                    out_v_next    = 1'b1;
                    pend_v_next   = 1'b0;
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            idx_reg    <= '0;
            sent_reg   <= 1'b0;
            vld_reg    <= '0;
            held_reg   <= '0;
            ws_reg     <= '0;
            wsk_reg    <= 1'b0;
            wf_reg     <= '0;
            wfk_reg    <= 1'b0;
            tf_reg     <= '0;
            tv_reg     <= 1'b0;
            prior_reg  <= '0;
            pm_reg     <= 1'b0;
            pd_reg     <= 1'b0;
            cp_reg     <= 1'b0;
            pend_v_reg <= 1'b0;
            out_v_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            sent_reg   <= sent_next;
            vld_reg    <= vld_next;
            held_reg   <= held_next;
            ws_reg     <= ws_next;
            wsk_reg    <= wsk_next;
            wf_reg     <= wf_next;
            wfk_reg    <= wfk_next;
            tf_reg     <= tf_next;
            tv_reg     <= tv_next;
            prior_reg  <= prior_next;
            pm_reg     <= pm_next;
            pd_reg     <= pd_next;
            cp_reg     <= cp_next;
            pend_v_reg <= pend_v_next;
            out_v_reg  <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg     <= pend_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
        if (ins_en)
        begin
            sseq_reg[ins_idx]  <= q_head.seq_num;
            sfrag_reg[ins_idx] <= q_head.frag_index;
            slen_reg[ins_idx]  <= q_head.pkt_len;
            shdl_reg[ins_idx]  <= q_head.payload_handle;
        end
    end
endmodule

// ===== sv/rtp_packet_reorder_buffer_unit.sv =====
// ----------------------------------------------------------------------------
// rtp_packet_reorder_buffer_unit
// reorders sequenced packet descriptors through a small slot table
// ----------------------------------------------------------------------------
// One descriptor word in gives zero or more result words out, the final one
// marked by last. Lengths that are whole transport packets pass straight
// through; other packets leave with their header dropped once they are the
// expected (sequence, fragment) pair, otherwise they wait in a table of SLOTS
// entries. Each item is classified and inserted, then a drain scan checks
// one slot per cycle, held while a match meets a busy output register; the
// next item is popped only once the scan is over. A two-word queue decouples
// input from the back end and an output register decouples the consumer.
// ----------------------------------------------------------------------------
module rtp_packet_reorder_buffer_unit #(
    parameter int SLOTS    = 15,
    parameter int SEQ_WRAP = 256
) (
    input  logic       clk,
    input  logic       rst_n,
    rprb_in_if.sink    in,
    rprb_out_if.source out
);
    import rprb_pkg::*;

    // front to queue
    logic  q_push;
    item_t q_in_item;
    logic  q_full;
    // queue to back
    logic  q_pop;
    logic  q_not_empty;
    item_t q_head;

    rprb_front u_front (
        .in     (in),
        .q_full (q_full),
        .q_push (q_push),
        .q_item (q_in_item)
    );

    rprb_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_in_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    rprb_back #(
        .SLOTS    (SLOTS),
        .SEQ_WRAP (SEQ_WRAP)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_not_empty),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .out     (out)
    );
endmodule

// ===== bench/rprb_checker.sv =====
// ----------------------------------------------------------------------------
// rprb_checker
// watches both channels, predicts the reorder results and compares them
// ----------------------------------------------------------------------------
module rprb_checker #(
    parameter int SLOTS    = 15,
    parameter int SEQ_WRAP = 256
) (
    input  logic clk,
    input  logic rst_n,
    rprb_in_if   in,
    rprb_out_if  out,
    output int   fails,
    output int   outstanding
);
    import rprb_pkg::*;

    typedef struct packed {
        result_t word;
        logic    last;
    } emitted_t;

    emitted_t awaited_q[$];
    emitted_t batch_q[$];

    logic              held_v[SLOTS];
    logic [SEQ_W-1:0]  held_seq[SLOTS];
    logic [FRAG_W-1:0] held_frag[SLOTS];
    logic [LEN_W-1:0]  held_len[SLOTS];
    logic [15:0]       held_handle[SLOTS];
    int                held_cnt;
    logic [SEQ_W-1:0]  want_seq;
    logic              want_seq_known;
    logic [16:0]       want_frag;
    logic              want_frag_known;
    logic [FRAG_W-1:0] turn_frag;
    logic              turn_valid;
    logic [FRAG_W-1:0] prev_frag;
    logic              prefilling;
    logic              prefill_over;
    logic              clear_armed;

    assign outstanding = awaited_q.size();

    function automatic void queue_word(logic [15:0] h, logic s, logic [LEN_W-1:0] l);
        emitted_t e;
        e.word.handle = h;
        e.word.skip   = s;
        e.word.len    = l;
        e.last        = 1'b0;
        batch_q.push_back(e);
    endfunction

    function automatic logic [LEN_W-1:0] less_header(logic [LEN_W-1:0] l);
        return (l > 11'd12) ? l - 11'd12 : 11'd0;
    endfunction

    function automatic void step_seq();
        int s;
        s = int'(want_seq) + 1;
        if (s == SEQ_WRAP || s > 16'hffff)
            s = 0;
        want_seq  = s[15:0];
        want_frag = '0;
    endfunction

    function automatic void step_pair();
        if (turn_valid && want_frag == {1'b0, turn_frag})
        begin
            step_seq();
            turn_valid = 1'b0;
        end
        else if (want_frag < 17'h10000)
            want_frag = want_frag + 17'd1;
    endfunction

    function automatic void drain_table();
        logic sent;
        while (held_cnt != 0 && !prefilling)
        begin
            sent = 1'b0;
            for (int i = 0; i < SLOTS; i++)
            begin
                if (held_v[i] && held_seq[i] == want_seq && {1'b0, held_frag[i]} == want_frag)
                begin
                    queue_word(held_handle[i], 1'b1, less_header(held_len[i]));
                    held_v[i] = 1'b0;
                    held_cnt--;
                    step_pair();
                    sent = 1'b1;
                end
                if (held_cnt == 0)
                    break;
            end
            if (!sent)
            begin
                if (prefill_over)
                begin
                    step_seq();
                    prefill_over = 1'b0;
                end
                else
                    break;
            end
        end
    endfunction

    function automatic void predict_reorder(logic [LEN_W-1:0] len, logic [15:0] seq,
                                            logic [15:0] frag, logic [15:0] handle);
        logic direct;
        batch_q.delete();
        if (len % TS_PACKET == 0)
            queue_word(handle, 1'b0, len);
        else
        begin
            direct = 1'b0;
            if (clear_armed)
            begin
                for (int i = 0; i < SLOTS; i++)
                    held_v[i] = 1'b0;
                held_cnt        = 0;
                want_seq        = seq;
                want_seq_known  = 1'b1;
                want_frag       = {1'b0, frag};
                want_frag_known = 1'b1;
                clear_armed     = 1'b0;
            end
            if (!want_seq_known)
            begin
                want_seq       = seq;
                want_seq_known = 1'b1;
            end
            if (!want_frag_known)
            begin
                want_frag       = {1'b0, frag};
                want_frag_known = 1'b1;
            end
            if (frag == 0)
            begin
                if (held_cnt == 0)
                    prefilling = 1'b1;
                else
                begin
                    turn_frag  = prev_frag;
                    turn_valid = 1'b1;
                end
            end
            if (seq != want_seq && held_cnt == 0 && !prefilling)
                want_seq = seq;
            prev_frag = frag;
            if (!prefilling && seq == want_seq && {1'b0, frag} == want_frag)
            begin
                queue_word(handle, 1'b1, less_header(len));
                if (want_frag < 17'h10000)
                    want_frag = want_frag + 17'd1;
                direct = 1'b1;
            end
            if (!direct)
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (!held_v[i])
                    begin
                        held_v[i]      = 1'b1;
                        held_seq[i]    = seq;
                        held_frag[i]   = frag;
                        held_len[i]    = len;
                        held_handle[i] = handle;
                        held_cnt++;
                        break;
                    end
                end
                if (held_cnt >= SLOTS)
                begin
                    if (prefilling)
                    begin
                        prefilling   = 1'b0;
                        prefill_over = 1'b1;
                    end
                    else
                    begin
                        step_pair();
                        clear_armed = 1'b1;
                    end
                end
            end
        end
        drain_table();
        if (batch_q.size() > 0)
            batch_q[batch_q.size()-1].last = 1'b1;
        foreach (batch_q[i])
            awaited_q.push_back(batch_q[i]);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        emitted_t e;
        if (!rst_n)
        begin
            awaited_q.delete();
            for (int i = 0; i < SLOTS; i++)
                held_v[i] = 1'b0;
            held_cnt        = 0;
            want_seq        = '0;
            want_seq_known  = 1'b0;
            want_frag       = '0;
            want_frag_known = 1'b0;
            turn_frag       = '0;
            turn_valid      = 1'b0;
            prev_frag       = '0;
            prefilling      = 1'b0;
            prefill_over    = 1'b0;
            clear_armed     = 1'b0;
            fails           = 0;
        end
        else
        begin
            if (in.valid && in.ready)
                predict_reorder(in.pkt_len, in.seq_num, in.frag_index, in.payload_handle);
            if (out.valid && out.ready)
            begin
                if (awaited_q.size() == 0)
                begin
                    fails++;
                    if (fails <= 10)
                        $display("unexpected word: handle %h skip %b len %0d last %b",
                                 out.out_handle, out.skip_header, out.out_len, out.last);
                end
                else
                begin
                    e = awaited_q.pop_front();
                    if (e.word.handle !== out.out_handle || e.word.skip !== out.skip_header ||
                        e.word.len !== out.out_len || e.last !== out.last)
                    begin
                        fails++;
                        if (fails <= 10)
                            $display({"mismatch: exp h %h s %b l %0d last %b, ",
                                      "got h %h s %b l %0d last %b"},
                                     e.word.handle, e.word.skip, e.word.len, e.last,
                                     out.out_handle, out.skip_header, out.out_len, out.last);
                    end
                end
            end
        end
    end

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// stimulus and verdict for the rtp packet reorder buffer
// ----------------------------------------------------------------------------
// Drives directed and randomised descriptor words with random idling on both
// channels; the checker beside the block predicts and compares every result
// word and hands back its failure count and the number still awaited.
// ----------------------------------------------------------------------------
module tb_top;
    import rprb_pkg::*;

    localparam int STALL_LIMIT = 6000;   // cycles with no word moving
    localparam int SETTLE      = 400;    // longer than a full drain scan

    logic clk;
    logic rst_n;
    int   fails;
    int   outstanding;
    int   idle_cycles;
    logic long_hold;     // request for one long receiver hold-off
    logic calm;          // no idling on either side

    rprb_in_if  in_ch ();
    rprb_out_if out_ch ();

    rtp_packet_reorder_buffer_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .in    (in_ch.sink),
        .out   (out_ch.source)
    );

    rprb_checker chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .in          (in_ch),
        .out         (out_ch),
        .fails       (fails),
        .outstanding (outstanding)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // watchdog: counts cycles in which no word is accepted on either side
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("[rtp_packet_reorder_buffer_unit] ERROR");
            $finish;
        end
    end

    // receiver: mostly ready, short stalls, the odd long one, one long hold-off
    initial
    begin
        int r;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold)
            begin
                out_ch.ready <= 1'b0;
                repeat (300) @(posedge clk);
                long_hold = 1'b0;
            end
            else if (calm)
                out_ch.ready <= 1'b1;
            else
            begin
                r = $urandom_range(0, 199);
                if (r == 0)
                begin
                    out_ch.ready <= 1'b0;
                    repeat ($urandom_range(20, 60)) @(posedge clk);
                end
                else
                    out_ch.ready <= (r > 60);
            end
        end
    end

    // offer one descriptor word, after a random gap, and wait for acceptance
    task automatic send_word(logic [10:0] len, logic [15:0] seq, logic [15:0] frag,
                             logic [15:0] handle);
        int r;
        int gap;
        r   = $urandom_range(0, 9);
        gap = calm ? 0 : (r < 6) ? 0 : (r < 9) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.pkt_len        <= len;
        in_ch.seq_num        <= seq;
        in_ch.frag_index     <= frag;
        in_ch.payload_handle <= handle;
        do @(posedge clk); while (!in_ch.ready);
    endtask

    // sender pause until the checker expects nothing more
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    // non-multiple length in the allowed range
    function automatic logic [10:0] odd_len();
        logic [10:0] l;
        l = 11'($urandom_range(1, 2047));
        if (l % TS_PACKET == 0)
            l = l + 11'd1;
        return l;
    endfunction

    initial
    begin
        int          r;
        logic [15:0] cur_seq;
        logic [15:0] cur_frag;
        logic [10:0] len;
        rst_n                = 1'b0;
        long_hold            = 1'b0;
        calm                 = 1'b0;
        idle_cycles          = 0;
        in_ch.valid          = 1'b0;
        in_ch.pkt_len        = '0;
        in_ch.seq_num        = '0;
        in_ch.frag_index     = '0;
        in_ch.payload_handle = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // pass-through words: zero length, one and ten transport packets
        send_word(11'd0, 16'hffff, 16'hffff, 16'h0000);
        send_word(11'd188, 16'h0000, 16'h0000, 16'hffff);
        send_word(11'd1880, 16'h1234, 16'h0001, 16'ha5a5);
        // first sequenced word sets the wanted pair and goes out directly
        send_word(11'd2047, 16'd10, 16'd5, 16'h0101);
        // one ahead is held, then the wanted one (short, saturating) drains it
        send_word(11'd100, 16'd10, 16'd7, 16'h0102);
        send_word(11'd5, 16'd10, 16'd6, 16'h0103);
        send_word(11'd12, 16'd10, 16'd8, 16'h0104);
        // fragment zero on an empty table starts prefill; fill every slot
        send_word(11'd300, 16'd11, 16'd0, 16'h0200);
        for (int i = 14; i >= 1; i--)
            send_word(11'd40 + 11'(i), 16'd11, 16'(i), 16'h0200 + 16'(i));
        // fragment zero of sequence 255 meets an empty table and starts a new prefill, so both words are held
        send_word(11'd99, 16'd255, 16'd0, 16'h0300);
        send_word(11'd99, 16'd0, 16'd1, 16'h0301);
        wait_drained();

        // random part: mostly ordered fragment runs with local reordering
        cur_seq  = 16'($urandom_range(0, 255));
        cur_frag = '0;
        for (int n = 0; n < 150; n++)
        begin
            if (n == 40)
                long_hold = 1'b1;
            if (n == 90)
                wait_drained();
            calm = (n >= 100 && n < 120);
            r = $urandom_range(0, 99);
            if (r < 8)
                send_word(11'(188 * $urandom_range(0, 10)), 16'($urandom()),
                          16'($urandom()), 16'($urandom()));
            else if (r < 20)
                send_word(11'($urandom()), 16'($urandom()), 16'($urandom()),
                          16'($urandom()));
            else
            begin
                len = odd_len();
                send_word(len, cur_seq, cur_frag + 16'($urandom_range(0, 2)),
                          16'($urandom()));
                cur_frag = cur_frag + 16'd1;
                if ($urandom_range(0, 9) == 0)
                begin
                    cur_seq  = (cur_seq + 16'd1) & 16'h00ff;
                    cur_frag = '0;
                end
            end
        end
        in_ch.valid <= 1'b0;
        calm = 1'b0;

        do @(posedge clk); while (outstanding != 0);
        repeat (SETTLE) @(posedge clk);
        if (fails == 0 && outstanding == 0)
            $display("[rtp_packet_reorder_buffer_unit] OK");
        else
            $display("[rtp_packet_reorder_buffer_unit] ERROR");
        $finish;
    end

endmodule
